// ===== hdl/mml_command_event_decoder_assert.svh =====
// Assertion macros shared by the decoder's checker.
// Used by mmlced_checker.sv; depends on nothing else.
`ifndef MML_COMMAND_EVENT_DECODER_ASSERT_SVH
`define MML_COMMAND_EVENT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMLCED_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mmlced assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MMLCED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mmlced assertion failed");

`endif

// ===== hdl/mmlced_pkg.sv =====
// Types and constants of the music command event decoder.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package mmlced_pkg;

	localparam int TIME_BITS_DEF = 32;

	typedef enum logic [2:0] {
		PH_OPCODE,
		PH_PARAM,
		PH_NOTE_TONE,
		PH_NOTE_ON,
		PH_NOTE_OFF
	} phase_t;

	localparam logic [7:0] OP_NOTE_OFF  = 8'h80;
	localparam logic [7:0] OP_NOTE_ON   = 8'h90;
	localparam logic [7:0] OP_NOTE_TONE = 8'h97;
	localparam logic [7:0] OP_TEMPO     = 8'hF4;
	localparam logic [7:0] OP_TONE      = 8'hF5;
	localparam logic [7:0] OP_VOLUME_A  = 8'hF8;
	localparam logic [7:0] OP_VOLUME_B  = 8'hF9;

	localparam logic [3:0] KIND_OFF    = 4'd0;
	localparam logic [3:0] KIND_TEMPO  = 4'd1;
	localparam logic [3:0] KIND_TONE   = 4'd2;
	localparam logic [3:0] KIND_VOLUME = 4'd3;
	localparam logic [3:0] KIND_ON     = 4'd9;

endpackage
`default_nettype wire

// ===== hdl/mmlced_if.sv =====
// Handshake channels of the decoder: command bytes in, events out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface mmlced_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] cmd_byte;
	logic [3:0] channel;
	logic       channel_start;

	modport source(output valid, cmd_byte, channel, channel_start, input ready);
	modport sink(input valid, cmd_byte, channel, channel_start, output ready);
endinterface

interface mmlced_evt_if;
	logic        valid;
	logic        ready;
	logic [7:0]  event_code;
	logic [7:0]  param;
	logic [31:0] event_time;
	logic [3:0]  kind;
	logic [3:0]  event_channel;
	logic [31:0] sequence_res;
	logic        bad_opcode;

	modport source(output valid, event_code, param, event_time, kind, event_channel,
		sequence_res, bad_opcode, input ready);
	modport sink(input valid, event_code, param, event_time, kind, event_channel,
		sequence_res, bad_opcode, output ready);
endinterface
`default_nettype wire

// ===== hdl/mml_command_event_decoder.sv =====
// Top level of the music command event decoder.
// Depends on mmlced_pkg and the channel interfaces in mmlced_if.sv.
//
// Takes one command byte per cycle, except while a byte with an event waits
// on a full event register, and decodes it against the channel's parse phase,
// emitting at most one timestamped event per byte. A byte is captured in an
// input register and decoded there; as it advances it updates phase, time and
// the sequence count and loads the event register. Throughput is one byte per
// clock under that condition, set by the single decode stage. Bytes that
// produce no event pass through without using the event register, so they
// move on even while an event waits downstream.
// Tick time saturates at 2**TIME_BITS - 1 and its low 32 bits are reported.
// Unknown opcode bytes are skipped and reported with bad_opcode set; they do
// not consume a sequence number.
`timescale 1ns / 1ps
`default_nettype none
module mml_command_event_decoder #(
	parameter int TIME_BITS = mmlced_pkg::TIME_BITS_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	mmlced_cmd_if.sink    cmd,
	mmlced_evt_if.source  evt
);
	import mmlced_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [3:0] ch_s1;
	logic       start_s1;

	// Decoder state.
	phase_t                 phase_q;
	logic [7:0]             pend_q;
	logic [TIME_BITS-1:0]   time_q;
	logic [31:0]            count_q;

	// Event register.
	logic        valid_s2;
	logic [7:0]  code_s2;
	logic [7:0]  param_s2;
	logic [31:0] time_s2;
	logic [3:0]  kind_s2;
	logic [3:0]  ch_s2;
	logic [31:0] seq_s2;
	logic        bad_s2;

	// Decode.
	phase_t               phase_b;
	logic [7:0]           pend_b;
	logic [TIME_BITS-1:0] time_b;
	logic [TIME_BITS:0]   time_sum;
	logic [TIME_BITS-1:0] time_adv;
	phase_t               phase_nx;
	logic [7:0]           pend_nx;
	logic [TIME_BITS-1:0] time_nx;
	logic [63:0]          time_ext;
	logic                 has_res;
	logic                 bad;
	logic [7:0]           code;
	logic [7:0]           prm;
	logic [3:0]           kind;
	logic                 adv_s1;

	// A channel start abandons any partial command and restarts time.
	assign phase_b  = start_s1 ? PH_OPCODE : phase_q;
	assign pend_b   = start_s1 ? 8'h00 : pend_q;
	assign time_b   = start_s1 ? '0 : time_q;
	assign time_sum = {1'b0, time_b} + (TIME_BITS+1)'(byte_s1);
	assign time_adv = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];

	always_comb begin
		phase_nx = phase_b;
		pend_nx  = pend_b;
		time_nx  = time_b;
		has_res  = 1'b0;
		bad      = 1'b0;
		code     = byte_s1;
		prm      = 8'h00;
		kind     = KIND_OFF;
		case (phase_b)
			PH_OPCODE: begin
				case (byte_s1)
					OP_NOTE_OFF: begin
						pend_nx  = byte_s1;
						phase_nx = PH_PARAM;
						has_res  = 1'b1;
						code     = OP_NOTE_OFF;
						kind     = KIND_OFF;
					end
					OP_TEMPO, OP_TONE, OP_VOLUME_A, OP_VOLUME_B: begin
						pend_nx  = byte_s1;
						phase_nx = PH_PARAM;
					end
					OP_NOTE_ON: begin
						pend_nx  = byte_s1;
						phase_nx = PH_NOTE_TONE;
						has_res  = 1'b1;
						code     = OP_NOTE_ON;
						kind     = KIND_ON;
					end
					default: begin
						has_res = 1'b1;
						bad     = 1'b1;
					end
				endcase
			end
			PH_PARAM: begin
				phase_nx = PH_OPCODE;
				if (pend_b == OP_NOTE_OFF) begin
					time_nx = time_adv;
				end else begin
					has_res = 1'b1;
					code    = pend_b;
					prm     = byte_s1;
					if (pend_b == OP_TEMPO) begin
						kind = KIND_TEMPO;
					end else if (pend_b == OP_TONE) begin
						kind = KIND_TONE;
					end else begin
						kind = KIND_VOLUME;
					end
				end
			end
			PH_NOTE_TONE: begin
				phase_nx = PH_NOTE_ON;
				has_res  = 1'b1;
				code     = OP_NOTE_TONE;
				prm      = byte_s1;
				kind     = KIND_TONE;
			end
			PH_NOTE_ON: begin
				// The off event is stamped at the end of the on-length.
				phase_nx = PH_NOTE_OFF;
				time_nx  = time_adv;
				has_res  = 1'b1;
				code     = OP_NOTE_OFF;
				kind     = KIND_OFF;
			end
			PH_NOTE_OFF: begin
				phase_nx = PH_OPCODE;
				time_nx  = time_adv;
			end
			default: begin
				phase_nx = PH_OPCODE;
			end
		endcase
	end

	assign time_ext = 64'(time_nx);

	// A byte without an event never waits on the event register.
	assign adv_s1    = valid_s1 && (!has_res || !valid_s2 || evt.ready);
	assign cmd.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			byte_s1  <= cmd.cmd_byte;
			ch_s1    <= cmd.channel;
			start_s1 <= cmd.channel_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			pend_q  <= 8'h00;
			time_q  <= '0;
			count_q <= 32'd0;
		end else if (adv_s1) begin
			phase_q <= phase_nx;
			pend_q  <= pend_nx;
			time_q  <= time_nx;
			if (has_res && !bad) begin
				count_q <= count_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && has_res) begin
			valid_s2 <= 1'b1;
		end else if (evt.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_res) begin
			code_s2  <= code;
			param_s2 <= prm;
			time_s2  <= time_ext[31:0];
			kind_s2  <= kind;
			ch_s2    <= ch_s1;
			seq_s2   <= count_q;
			bad_s2   <= bad;
		end
	end

	assign evt.valid         = valid_s2;
	assign evt.event_code    = code_s2;
	assign evt.param         = param_s2;
	assign evt.event_time    = time_s2;
	assign evt.kind          = kind_s2;
	assign evt.event_channel = ch_s2;
	assign evt.sequence_res  = seq_s2;
	assign evt.bad_opcode    = bad_s2;

endmodule
`default_nettype wire

// ===== hdl/mmlced_checker.sv =====
// Port-level checker for the music command event decoder, bound to the top level.
// Depends on mmlced_pkg and mml_command_event_decoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "mml_command_event_decoder_assert.svh"
module mmlced_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        evt_valid,
	input wire        evt_ready,
	input wire [7:0]  event_code,
	input wire [7:0]  param,
	input wire [3:0]  kind,
	input wire [31:0] sequence_res,
	input wire        bad_opcode
);
	import mmlced_pkg::*;

	logic [31:0] exp_seq_q;

	// Sequence numbers count the good events transferred so far.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_seq_q <= 32'd0;
		end else if (evt_valid && evt_ready && !bad_opcode) begin
			exp_seq_q <= exp_seq_q + 32'd1;
		end
	end

	`MMLCED_ASSERT_NEXT(a_evt_hold, clk, arst_n, evt_valid && !evt_ready, evt_valid && $stable(sequence_res) && $stable(event_code))
	`MMLCED_ASSERT_NOW(a_seq_order, clk, arst_n, evt_valid, sequence_res == exp_seq_q)
	`MMLCED_ASSERT_NOW(a_bad_fields, clk, arst_n, evt_valid && bad_opcode, kind == KIND_OFF && param == 8'h00)
	`MMLCED_ASSERT_NOW(a_on_kind, clk, arst_n, evt_valid && !bad_opcode && event_code == OP_NOTE_ON, kind == KIND_ON && param == 8'h00)

endmodule

bind mml_command_event_decoder mmlced_checker u_mmlced_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.event_code   (evt.event_code),
	.param        (evt.param),
	.kind         (evt.kind),
	.sequence_res (evt.sequence_res),
	.bad_opcode   (evt.bad_opcode)
);
`default_nettype wire
